// ===== hdl/scem_pkg.sv =====
// ----------------------------------------------------------------------------
// scem_pkg
// Shared types, constants and helpers for the cumulative energy map block.
// ----------------------------------------------------------------------------
`default_nettype none

package scem_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int MAX_HEIGHT      = 4096;
   localparam int MAX_CHANNELS    = 4;
   localparam int SAMPLE_BITS     = 16;
   localparam int CUMULATIVE_BITS = 40;

   localparam int COL_BITS    = 12;
   localparam int ROW_BITS    = 12;
   localparam int DIM_BITS    = 13;
   localparam int CH_BITS     = 3;
   localparam int ENERGY_BITS = 20;
   localparam int PIXEL_BITS  = MAX_CHANNELS * SAMPLE_BITS;

   localparam logic [ENERGY_BITS-1:0] BORDER_ENERGY = 20'd1000000;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET    = 13'd640;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET   = 13'd480;
   localparam logic [CH_BITS-1:0]  CHANNELS_RESET = 3'd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_CHANNELS_USED = 2'd2
   } csr_index_type;

   typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_0;
      logic [SAMPLE_BITS-1:0] sample_1;
      logic [SAMPLE_BITS-1:0] sample_2;
      logic [SAMPLE_BITS-1:0] sample_3;
   } req_payload_type;

   typedef struct packed {
      logic [COL_BITS-1:0]        column;
      logic [ROW_BITS-1:0]        row;
      logic [ENERGY_BITS-1:0]     local_energy;
      logic [CUMULATIVE_BITS-1:0] cumulative_energy;
      logic                       frame_done;
   } rsp_payload_type;

   // classified pixel, front to back
   typedef struct packed {
      pixel_type           pixel;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      logic                has_work;  // row >= 1: a result is due
      logic                border;
      logic                first_pr;  // result row is row 0
      logic                last_row;
      logic                last_col;
      logic                right_ok;  // column + 1 inside the frame
      logic [CH_BITS-1:0]  nch;
   } work_item_type;

   function automatic logic [SAMPLE_BITS-1:0] absdiff(input logic [SAMPLE_BITS-1:0] a,
                                                      input logic [SAMPLE_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [CUMULATIVE_BITS-1:0] min2(input logic [CUMULATIVE_BITS-1:0] a,
                                                       input logic [CUMULATIVE_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CUMULATIVE_BITS-1:0] sat_add(
         input logic [CUMULATIVE_BITS-1:0] a,
         input logic [ENERGY_BITS-1:0]     b);
      logic [CUMULATIVE_BITS:0] s;
      s = {1'b0, a} + {{(CUMULATIVE_BITS+1-ENERGY_BITS){1'b0}}, b};
      return s[CUMULATIVE_BITS] ? {CUMULATIVE_BITS{1'b1}} : s[CUMULATIVE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/scem_ram.sv =====
// ----------------------------------------------------------------------------
// scem_ram
// Generic RAM: one write port, two registered read ports, read-old on collision.
// ----------------------------------------------------------------------------
`default_nettype none

module scem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic                       re,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
   output logic      [WIDTH-1:0]           rdata_a,
   output logic      [WIDTH-1:0]           rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem_ff[raddr_a];
         rdata_b <= mem_ff[raddr_b];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/scem_front.sv =====
// ----------------------------------------------------------------------------
// scem_front
// Config registers, raster position counters and pixel classification.
// ----------------------------------------------------------------------------
`default_nettype none

module scem_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [scem_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [scem_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire scem_pkg::req_payload_type             req_data,
   input  wire logic                                  q_full,
   output logic                                       q_push,
   output scem_pkg::work_item_type                    q_item
);
   import scem_pkg::*;

   logic [DIM_BITS-1:0] width_ff, height_ff;
   logic [CH_BITS-1:0]  chan_ff;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [DIM_BITS-1:0] w_eff, h_eff, col_x, row_x, c, r, cn, rn;
   logic [CH_BITS-1:0]  nch;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         chan_ff   <= CHANNELS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data;
            CSR_CHANNELS_USED: chan_ff   <= csr_write_data[CH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp registers to legal ranges
   always_comb begin
      w_eff = (width_ff == '0) ? DIM_BITS'(1) :
              (width_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff < DIM_BITS'(2)) ? DIM_BITS'(2) :
              (height_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_ff;
      nch   = (chan_ff == '0) ? CH_BITS'(1) :
              (chan_ff > CH_BITS'(MAX_CHANNELS)) ? CH_BITS'(MAX_CHANNELS) : chan_ff;
   end

   // position of this pixel; a shrunk frame wraps the kept counters
   always_comb begin
      col_x = {1'b0, col_ff};
      row_x = {1'b0, row_ff};
      if (col_x >= w_eff) begin
         c = '0;
         r = row_x + DIM_BITS'(1);
      end else begin
         c = col_x;
         r = row_x;
      end
      if (r >= h_eff) begin
         r = '0;
      end
      cn = c + DIM_BITS'(1);
      rn = r + DIM_BITS'(1);
      if (cn >= w_eff) begin
         col_in = '0;
         row_in = (rn >= h_eff) ? '0 : rn[ROW_BITS-1:0];
      end else begin
         col_in = cn[COL_BITS-1:0];
         row_in = r[ROW_BITS-1:0];
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      q_item.pixel[0] = req_data.sample_0;
      q_item.pixel[1] = req_data.sample_1;
      q_item.pixel[2] = req_data.sample_2;
      q_item.pixel[3] = req_data.sample_3;
      q_item.col      = c[COL_BITS-1:0];
      q_item.row      = r[ROW_BITS-1:0];
      q_item.has_work = (r != '0);
      q_item.first_pr = (r == DIM_BITS'(1));
      q_item.last_row = (r == h_eff - DIM_BITS'(1));
      q_item.last_col = (c == w_eff - DIM_BITS'(1));
      q_item.right_ok = (cn < w_eff);
      q_item.border   = (c == '0) || (r == DIM_BITS'(1)) || (c == w_eff - DIM_BITS'(1));
      q_item.nch      = nch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (q_push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/scem_queue.sv =====
// ----------------------------------------------------------------------------
// scem_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module scem_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire scem_pkg::work_item_type  push_item,
   input  wire logic                     pop,
   output scem_pkg::work_item_type       head,
   output logic                          empty,
   output logic                          full
);
   import scem_pkg::*;

   work_item_type         entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_BITS:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + (Q_PTR_BITS+1)'(1);
      if (pop && !push) count_in = count_ff - (Q_PTR_BITS+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + Q_PTR_BITS'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + Q_PTR_BITS'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/scem_back.sv =====
// ----------------------------------------------------------------------------
// scem_back
// Line memories, energy and cumulative pipeline, and result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scem_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire scem_pkg::work_item_type  head,
   input  wire logic                     q_empty,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output scem_pkg::rsp_payload_type     rsp_data
);
   import scem_pkg::*;

   logic adv, hazard;
   logic [COL_BITS-1:0] head_col_p1;

   // memories
   logic [PIXEL_BITS-1:0]      pix_rd_a, pix_rd_b;
   logic [CUMULATIVE_BITS-1:0] cum_rd_a, cum_rd_b;

   // stage 1
   logic                       s1_valid_ff;
   work_item_type              s1_ff;
   logic [COL_BITS-1:0]        s1_col_p1;
   pixel_type                  pa, pb;
   logic [CUMULATIVE_BITS-1:0] mid, rgt, lft, m3;
   logic [ENERGY_BITS-1:0]     acc, e1;
   logic [CUMULATIVE_BITS-1:0] held_ff;

   // last write into cumulative line, for the read at the same edge
   logic                       lw_valid_ff;
   logic [COL_BITS-1:0]        lw_addr_ff;
   logic [CUMULATIVE_BITS-1:0] lw_data_ff;

   // stage 2
   logic                       s2_valid_ff;
   logic [COL_BITS-1:0]        s2_col_ff;
   logic [ROW_BITS-1:0]        s2_row_ff;
   logic [ENERGY_BITS-1:0]     s2_e_ff;
   logic [CUMULATIVE_BITS-1:0] s2_m3_ff, cum2;
   logic                       s2_first_ff, s2_last_row_ff, s2_last_col_ff;
   logic [CUMULATIVE_BITS-1:0] p1_ff, p2_ff;

   // stage 3
   logic                       s3_valid_ff;
   logic [COL_BITS-1:0]        s3_col_ff;
   logic [ROW_BITS-1:0]        s3_row_ff;
   logic [ENERGY_BITS-1:0]     s3_e_ff;
   logic [CUMULATIVE_BITS-1:0] s3_cur_ff, s3_p1_ff, s3_p2_ff, ma, mb;
   logic                       s3_last_row_ff, s3_last_col_ff;
   logic [2:0]                 s3_mask;

   // emit stage
   logic [2:0]                 e_pend_ff, e_pend_in, sel, rem;
   logic [COL_BITS-1:0]        e_col_ff;
   logic [ROW_BITS-1:0]        e_row_ff;
   logic [ENERGY_BITS-1:0]     e_e_ff;
   logic [CUMULATIVE_BITS-1:0] e_cur_ff, e_ma_ff, e_mb_ff;
   logic                       out_load, rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_data_ff, rsp_sel;

   // ---------------- issue ----------------
   assign head_col_p1 = head.col + COL_BITS'(1);
   assign hazard = s1_valid_ff && ((s1_ff.col == head.col) || (s1_ff.col == head_col_p1));
   assign q_pop  = !q_empty && adv && !hazard;

   scem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_pixel_line (
      .clock   (clock),
      .we      (q_pop),
      .waddr   (head.col),
      .wdata   (head.pixel),
      .re      (q_pop),
      .raddr_a (head.col),
      .raddr_b (head_col_p1),
      .rdata_a (pix_rd_a),
      .rdata_b (pix_rd_b)
   );

   scem_ram #(.WIDTH(CUMULATIVE_BITS), .DEPTH(MAX_WIDTH)) u_cumulative_line (
      .clock   (clock),
      .we      (adv && s2_valid_ff),
      .waddr   (s2_col_ff),
      .wdata   (cum2),
      .re      (q_pop),
      .raddr_a (head.col),
      .raddr_b (head_col_p1),
      .rdata_a (cum_rd_a),
      .rdata_b (cum_rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
         held_ff     <= '0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= q_pop && head.has_work;
         lw_valid_ff <= s2_valid_ff;
         if (s1_valid_ff) held_ff <= mid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------- stage 1: energy and min of the three above ----------------
   assign s1_col_p1 = s1_ff.col + COL_BITS'(1);

   always_comb begin
      pa  = pix_rd_a;
      pb  = pix_rd_b;
      mid = (lw_valid_ff && lw_addr_ff == s1_ff.col) ? lw_data_ff : cum_rd_a;
      rgt = (lw_valid_ff && lw_addr_ff == s1_col_p1) ? lw_data_ff : cum_rd_b;
      if (!s1_ff.right_ok) rgt = mid;
      lft = (s1_ff.col == '0) ? mid : held_ff;
      m3  = min2(lft, min2(mid, rgt));
      acc = '0;
      for (int l = 0; l < MAX_CHANNELS; l++) begin
         if (CH_BITS'(l) < s1_ff.nch) begin
            acc = acc + ENERGY_BITS'(absdiff(s1_ff.pixel[l], pa[l]))
                      + ENERGY_BITS'(absdiff(pb[l], pa[l]));
         end
      end
      e1 = s1_ff.border ? BORDER_ENERGY : acc;
   end

   always_ff @(posedge clock) begin
      if (q_pop) s1_ff <= head;
      if (adv) begin
         lw_addr_ff     <= s2_col_ff;
         lw_data_ff     <= cum2;
         s2_col_ff      <= s1_ff.col;
         s2_row_ff      <= s1_ff.row;
         s2_e_ff        <= e1;
         s2_m3_ff       <= m3;
         s2_first_ff    <= s1_ff.first_pr;
         s2_last_row_ff <= s1_ff.last_row;
         s2_last_col_ff <= s1_ff.last_col;
      end
   end

   // ---------------- stage 2: cumulative value ----------------
   assign cum2 = s2_first_ff ? {{(CUMULATIVE_BITS-ENERGY_BITS){1'b0}}, s2_e_ff}
                             : sat_add(s2_m3_ff, s2_e_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s2_valid_ff) begin
            p1_ff <= cum2;
            p2_ff <= p1_ff;
         end
         s3_col_ff      <= s2_col_ff;
         s3_row_ff      <= s2_row_ff;
         s3_e_ff        <= s2_e_ff;
         s3_cur_ff      <= cum2;
         s3_p1_ff       <= p1_ff;
         s3_p2_ff       <= p2_ff;
         s3_last_row_ff <= s2_last_row_ff;
         s3_last_col_ff <= s2_last_col_ff;
      end
   end

   // ---------------- stage 3: last-row minima ----------------
   always_comb begin
      ma = min2((s3_col_ff >= COL_BITS'(2)) ? s3_p2_ff : s3_p1_ff,
                min2(s3_p1_ff, s3_cur_ff));
      mb = min2((s3_col_ff != '0) ? s3_p1_ff : s3_cur_ff, s3_cur_ff);
      s3_mask = {s3_last_row_ff && s3_last_col_ff,
                 s3_last_row_ff && (s3_col_ff != '0),
                 1'b1};
   end

   // ---------------- emit: up to three transfers per pixel ----------------
   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (e_pend_ff[0])      sel = 3'b001;
      else if (e_pend_ff[1]) sel = 3'b010;
      else                   sel = 3'b100;
      rem = e_pend_ff & ~sel;
      adv = (e_pend_ff == '0) || (out_load && rem == '0);

      if (adv)           e_pend_in = s3_valid_ff ? s3_mask : '0;
      else if (out_load) e_pend_in = rem;
      else               e_pend_in = e_pend_ff;

      rsp_valid_in = out_load ? (e_pend_ff != '0) : rsp_valid_ff;

      rsp_sel.column            = e_col_ff;
      rsp_sel.row               = e_row_ff;
      rsp_sel.local_energy      = BORDER_ENERGY;
      rsp_sel.cumulative_energy = sat_add(e_mb_ff, BORDER_ENERGY);
      rsp_sel.frame_done        = 1'b1;
      if (e_pend_ff[0]) begin
         rsp_sel.row               = e_row_ff - ROW_BITS'(1);
         rsp_sel.local_energy      = e_e_ff;
         rsp_sel.cumulative_energy = e_cur_ff;
         rsp_sel.frame_done        = 1'b0;
      end else if (e_pend_ff[1]) begin
         rsp_sel.column            = e_col_ff - COL_BITS'(1);
         rsp_sel.cumulative_energy = sat_add(e_ma_ff, BORDER_ENERGY);
         rsp_sel.frame_done        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_pend_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_pend_ff    <= e_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_col_ff <= s3_col_ff;
         e_row_ff <= s3_row_ff;
         e_e_ff   <= s3_e_ff;
         e_cur_ff <= s3_cur_ff;
         e_ma_ff  <= ma;
         e_mb_ff  <= mb;
      end
      if (out_load && e_pend_ff != '0) rsp_data_ff <= rsp_sel;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/seam_cumulative_energy_map_top.sv =====
// ----------------------------------------------------------------------------
// seam_cumulative_energy_map_top
// A result goes out after the pixel transfer that completes it, through the
//   queue, stages 1 to 3 and the emit stage (results lag one row of pixels).
// Throughput: 1 pixel per cycle while nothing stalls; a last-row pixel yields up
//   to 3 transfers through the single rsp register, which stalls the back.
// Widths below 3 add bubbles on the cumulative line write/read turnaround.
// Reset: synchronous; clears counters, pipeline valids, config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module seam_cumulative_energy_map_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [scem_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [scem_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire scem_pkg::req_payload_type           req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output scem_pkg::rsp_payload_type                rsp_data
);
   import scem_pkg::*;

   // front: config, raster counters, classification of each pixel
   logic          q_push, q_pop, q_empty, q_full;
   work_item_type q_item, q_head;

   scem_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_item)
   );

   // decoupling queue: back may stall on last-row bursts while front keeps going
   scem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: line memories, energy, cumulative min path, result transfers
   scem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/scem_checker.sv =====
// ----------------------------------------------------------------------------
// scem_checker
// Port-level checks for the cumulative energy map block.
// ----------------------------------------------------------------------------
`default_nettype none

module scem_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire scem_pkg::rsp_payload_type rsp_data
);
   import scem_pkg::*;

   // a stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transfer changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_done_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.local_energy == BORDER_ENERGY)
      else $error("frame_done on a non-border result");

   a_cum_ge_local: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cumulative_energy >=
                    {{(CUMULATIVE_BITS-ENERGY_BITS){1'b0}}, rsp_data.local_energy})
      else $error("cumulative energy below local energy");

endmodule

bind seam_cumulative_energy_map_top scem_checker u_scem_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/sv/scem_energy_checker.sv =====
// ----------------------------------------------------------------------------
// scem_energy_checker
// Watches the csr, req and rsp ports of the cumulative energy map block,
// predicts every result from its own copy of the line stores and counters,
// and compares each rsp transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module scem_energy_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [scem_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [scem_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire scem_pkg::req_payload_type           req_data,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire scem_pkg::rsp_payload_type           rsp_data,
   output int                                       fail_count,
   output int                                       pending
);
   import scem_pkg::*;

   localparam logic [CUMULATIVE_BITS-1:0] CUM_ALL_ONES = {CUMULATIVE_BITS{1'b1}};

   logic [SAMPLE_BITS-1:0]     prev_row_samples [MAX_WIDTH][MAX_CHANNELS];
   logic [CUMULATIVE_BITS-1:0] cum_row [MAX_WIDTH];
   logic [CUMULATIVE_BITS-1:0] left_cum;
   int unsigned                next_col, next_row;
   logic [DIM_BITS-1:0]        width_reg, height_reg;
   logic [CH_BITS-1:0]         channels_reg;
   rsp_payload_type            expected_results [$];

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [CUMULATIVE_BITS-1:0] lowest(logic [CUMULATIVE_BITS-1:0] a,
                                                        logic [CUMULATIVE_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CUMULATIVE_BITS-1:0] add_clipped(
         logic [CUMULATIVE_BITS-1:0] a, int unsigned e);
      logic [CUMULATIVE_BITS:0] s;
      s = {1'b0, a} + (CUMULATIVE_BITS+1)'(e);
      return s[CUMULATIVE_BITS] ? CUM_ALL_ONES : s[CUMULATIVE_BITS-1:0];
   endfunction

   task automatic queue_result(int unsigned c, int unsigned r, int unsigned e,
                               logic [CUMULATIVE_BITS-1:0] cum, logic done);
      rsp_payload_type x;
      x.column            = COL_BITS'(c);
      x.row               = ROW_BITS'(r);
      x.local_energy      = ENERGY_BITS'(e);
      x.cumulative_energy = cum;
      x.frame_done        = done;
      expected_results.push_back(x);
   endtask

   // energy map step for one accepted pixel
   task automatic predict_pixel(req_payload_type p);
      int unsigned w, h, nch, c, r, pr, e, k;
      logic [SAMPLE_BITS-1:0] s [MAX_CHANNELS];
      logic [CUMULATIVE_BITS-1:0] mid, cum, lft, rgt, a, b, d;
      w   = clamp(int'(width_reg), 1, MAX_WIDTH);
      h   = clamp(int'(height_reg), 2, MAX_HEIGHT);
      nch = clamp(int'(channels_reg), 1, MAX_CHANNELS);
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      c = next_col;
      r = next_row;
      s[0] = p.sample_0;
      s[1] = p.sample_1;
      s[2] = p.sample_2;
      s[3] = p.sample_3;
      if (r >= 1) begin
         pr = r - 1;
         e  = 0;
         if (c == 0 || pr == 0 || c == w - 1) begin
            e = BORDER_ENERGY;
         end else begin
            for (int l = 0; l < nch; l++) begin
               e += (s[l] > prev_row_samples[c][l]) ? s[l] - prev_row_samples[c][l]
                                                   : prev_row_samples[c][l] - s[l];
               e += (prev_row_samples[c+1][l] > prev_row_samples[c][l])
                    ? prev_row_samples[c+1][l] - prev_row_samples[c][l]
                    : prev_row_samples[c][l] - prev_row_samples[c+1][l];
            end
         end
         mid = cum_row[c];
         if (pr == 0) begin
            cum = CUMULATIVE_BITS'(e);
         end else begin
            lft = (c == 0) ? cum_row[0] : left_cum;
            rgt = (c + 1 < w) ? cum_row[c+1] : mid;
            cum = add_clipped(lowest(lft, lowest(mid, rgt)), e);
         end
         left_cum   = mid;
         cum_row[c] = cum;
         queue_result(c, pr, e, cum, 1'b0);
         // bottom row: results for the row being streamed now
         if (r == h - 1) begin
            if (c >= 1) begin
               k = c - 1;
               a = cum_row[(k > 0) ? k - 1 : 0];
               b = cum_row[k];
               d = cum_row[c];
               queue_result(k, r, BORDER_ENERGY,
                            add_clipped(lowest(a, lowest(b, d)), BORDER_ENERGY), 1'b0);
            end
            if (c == w - 1) begin
               a = cum_row[(c > 0) ? c - 1 : 0];
               b = cum_row[c];
               queue_result(c, r, BORDER_ENERGY,
                            add_clipped(lowest(a, b), BORDER_ENERGY), 1'b1);
            end
         end
      end
      for (int l = 0; l < MAX_CHANNELS; l++) prev_row_samples[c][l] = s[l];
      next_col = c + 1;
      if (next_col >= w) begin
         next_col = 0;
         next_row = r + 1;
         if (next_row >= h) next_row = 0;
      end
   endtask

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      if (fail_count < 40)
         $display("%0t rsp %0s: got %0h, want %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         fail_count   = 0;
         next_col     = 0;
         next_row     = 0;
         left_cum     = '0;
         width_reg    = WIDTH_RESET;
         height_reg   = HEIGHT_RESET;
         channels_reg = CHANNELS_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report("unexpected transfer", 64'(rsp_data.cumulative_energy), '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.column != want.column)
                  report("column", 64'(rsp_data.column), 64'(want.column));
               if (rsp_data.row != want.row)
                  report("row", 64'(rsp_data.row), 64'(want.row));
               if (rsp_data.local_energy != want.local_energy)
                  report("local_energy", 64'(rsp_data.local_energy),
                         64'(want.local_energy));
               if (rsp_data.cumulative_energy != want.cumulative_energy)
                  report("cumulative_energy", 64'(rsp_data.cumulative_energy),
                         64'(want.cumulative_energy));
               if (rsp_data.frame_done != want.frame_done)
                  report("frame_done", 64'(rsp_data.frame_done), 64'(want.frame_done));
            end
         end
         if (req_valid && !req_stall) predict_pixel(req_data);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   width_reg    = csr_write_data;
               CSR_IMAGE_HEIGHT:  height_reg   = csr_write_data;
               CSR_CHANNELS_USED: channels_reg = csr_write_data[CH_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_results.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_seam_cumulative_energy_map_top.sv =====
// ----------------------------------------------------------------------------
// tb_seam_cumulative_energy_map_top
// Streams whole frames of pixels into the energy map block under a range of
// frame sizes and channel counts, with bursty input and a patterned rsp stall.
// The checker beside the block predicts and compares; this module drives
// stimulus and prints the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_seam_cumulative_energy_map_top;
   import scem_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;
   logic                      req_valid;
   logic                      req_stall;
   req_payload_type           req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_payload_type           rsp_data;
   int                        fail_count;
   int                        pending;

   // pixel fill styles for a frame
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_CHECKER} fill_type;

   int burst_left;
   int random_pixels;

   seam_cumulative_energy_map_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   scem_energy_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // rsp stall: patterns drawn at random -- none, light, heavy, or toggling
   initial begin
      int mode, tick;
      rsp_stall = 1'b0;
      tick = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (tick % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 3) == 0);
            2: rsp_stall = ($urandom_range(0, 3) != 0);
            default: rsp_stall = tick[0];
         endcase
         tick++;
      end
   end

   // Register writes only while idle: queue drained, then the block's latency
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // One pixel transfer. Gaps between bursts are idle cycles on req_valid.
   task automatic send_pixel(req_payload_type p);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_data  = p;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Full frame, so counters sit at the frame start when the phase ends
   task automatic run_frame(int unsigned w, int unsigned h, int unsigned ch, fill_type fill);
      int unsigned ew, eh;
      req_payload_type p;
      settle();
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(h));
      write_reg(CSR_CHANNELS_USED, CSR_DATA_BITS'(ch));
      ew = clamp(w, 1, MAX_WIDTH);
      eh = clamp(h, 2, MAX_HEIGHT);
      for (int unsigned r = 0; r < eh; r++) begin
         for (int unsigned c = 0; c < ew; c++) begin
            case (fill)
               FILL_ZERO: p = '0;
               FILL_ONES: p = '1;
               FILL_CHECKER: p = ((r + c) % 2 == 1) ? '1 : '0;
               default: p = {$urandom, $urandom};
            endcase
            send_pixel(p);
         end
      end
   endtask

   initial begin
      int unsigned w, h;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_IMAGE_WIDTH;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_data         = '0;
      burst_left       = 0;
      random_pixels    = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: sample extremes, max gradient, narrow and clamped frame sizes
      run_frame(3, 2, 4, FILL_ONES);
      run_frame(4, 3, 4, FILL_CHECKER);
      run_frame(3, 4, 1, FILL_ZERO);
      run_frame(1, 2, 2, FILL_RANDOM);   // one column, every pixel on the border
      run_frame(2, 3, 7, FILL_RANDOM);   // too many channels clamps to four
      run_frame(0, 1, 0, FILL_RANDOM);   // zeros clamp up to the minimum sizes

      // random frames, mostly small
      while (random_pixels < 150) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
         run_frame(w, h, $urandom_range(0, 7),
                   ($urandom_range(0, 5) == 0) ? FILL_CHECKER : FILL_RANDOM);
         random_pixels += clamp(w, 1, MAX_WIDTH) * clamp(h, 2, MAX_HEIGHT);
      end

      // closing frame with the default channel count
      run_frame(5, 3, 3, FILL_RANDOM);

      settle();
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Hard stop if the handshakes hang
   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
